>>> rtl/core/encoder_footswitch_long_press_top_assert.svh
// Assertion macros used by the checker of the long-press detector.
`ifndef ENCODER_FOOTSWITCH_LONG_PRESS_TOP_ASSERT_SVH
`define ENCODER_FOOTSWITCH_LONG_PRESS_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define EFSLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define EFSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/efslp_pkg.sv
`default_nettype none
package efslp_pkg;

    localparam int NUM_ENC_DEF = 6;
    localparam int NUM_FS_DEF  = 4;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [9:0]  ENC_CLICK_RST    = 10'd16;
    localparam logic [9:0]  ENC_LEFT_RST     = 10'd30;
    localparam logic [9:0]  ENC_RIGHT_RST    = 10'd44;
    localparam logic [9:0]  FOOTSWITCH_RST   = 10'd101;

    // Register indexes, byte address is four times the index.
    localparam logic [2:0] REG_LONG_PRESS = 3'd0;
    localparam logic [2:0] REG_ENC_CLICK  = 3'd1;
    localparam logic [2:0] REG_ENC_LEFT   = 3'd2;
    localparam logic [2:0] REG_ENC_RIGHT  = 3'd3;
    localparam logic [2:0] REG_FOOTSWITCH = 3'd4;

    localparam logic [1:0] BTN_RELEASED = 2'd0;
    localparam logic [1:0] BTN_PRESSED  = 2'd1;
    localparam logic [1:0] BTN_LONG     = 2'd2;

    localparam logic [1:0] TURN_NONE  = 2'b00;
    localparam logic [1:0] TURN_RIGHT = 2'b01;
    localparam logic [1:0] TURN_LEFT  = 2'b11;

    typedef enum logic [1:0] {
        KIND_CLICK = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_FS    = 2'd3
    } t_key_kind;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] ptime;
    } t_entry;

    typedef struct packed {
        logic       tick;
        logic       hit;
        t_key_kind  kind;
        logic       down;
        logic       is_fs;
        logic [2:0] unit;
    } t_eval_cmd;

    typedef struct packed {
        logic       dev;
        logic [1:0] state;
        logic [2:0] unit;
        logic [1:0] turn;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/encoder_footswitch_long_press_top.sv
// Long-press detector for encoder push buttons and footswitches.
// Input words arrive on the s_axis channel: tuser says whether the word is a
// key event (0) or a one-millisecond tick (1); tdata carries the keycode and
// the pressed flag. Result words leave on the m_axis channel, one for each
// decoded key event and one for each button that reaches its long-press time
// on a tick; tlast marks the final result word that an input word causes.
// An unknown keycode, or a tick with no long press, gives no result word.
// The button states sit in a ring of cells that rotates by one place per
// cycle past a single evaluation unit while the output register can take
// results, so every input word costs one full turn of the ring, preceded by
// its acceptance and followed by a closing step for the last result.
// Each result passes through a pending register before the output register.
// A result word waits in the output register while the receiver stalls, and
// the ring stops turning until that register can take the next word.
// Reset clears the millisecond counter and all button states to released and
// loads the default keycode bases and long-press time.
// The APB port holds the long-press time and the four keycode bases; write it
// only while the block is idle.
`default_nettype none
module encoder_footswitch_long_press_top
    import efslp_pkg::*;
#(
    parameter int NUM_ENC = NUM_ENC_DEF,
    parameter int NUM_FS  = NUM_FS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // APB configuration port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [APB_AW-1:0]  paddr,
    input  wire  [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    // Input words
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [15:0]        s_axis_tdata,  // keycode[9:0], pressed[10], zero[15:11]
    input  wire                s_axis_tuser,  // mode
    // Result words
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [7:0]         m_axis_tdata,  // press_state[1:0], unit_index[4:2],
                                              // turn[6:5], zero[7]
    output logic               m_axis_tuser,  // device_kind
    output logic               m_axis_tlast   // last
);

    localparam int NUM_BTN = NUM_ENC + NUM_FS;
    localparam int BTN_W   = $clog2(NUM_BTN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_FLUSH
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_long_press;
    logic [9:0]  r_enc_click;
    logic [9:0]  r_enc_left;
    logic [9:0]  r_enc_right;
    logic [9:0]  r_footswitch;

    logic [31:0]      r_now;
    logic [BTN_W-1:0] r_pos;
    logic             r_tick;
    logic             r_key_hit;
    t_key_kind        r_kind;
    logic             r_down;
    logic [BTN_W-1:0] r_target;

    // The result held back until we know whether it is the last one.
    logic    r_pend_valid;
    t_result r_pend;

    logic    r_out_valid;
    t_result r_out;
    logic    r_out_last;

    // Input word fields.
    logic       in_mode;
    logic [9:0] in_keycode;
    logic       in_pressed;

    assign in_mode    = s_axis_tuser;
    assign in_keycode = s_axis_tdata[9:0];
    assign in_pressed = s_axis_tdata[10];

    logic s_accept;
    logic cfg_wr;
    logic out_free;
    logic step;
    logic out_load;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = (r_state == ST_PASS) && out_free;

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_LONG_PRESS: prdata = {16'd0, r_long_press};
            REG_ENC_CLICK:  prdata = {22'd0, r_enc_click};
            REG_ENC_LEFT:   prdata = {22'd0, r_enc_left};
            REG_ENC_RIGHT:  prdata = {22'd0, r_enc_right};
            REG_FOOTSWITCH: prdata = {22'd0, r_footswitch};
            default:        prdata = '0;
        endcase
    end

    // Keycode decode. Each range runs from its base up to, but not
    // including, base plus the number of units; the ranges are tried in the
    // order click, left, right, footswitch.
    logic [9:0] off_click;
    logic [9:0] off_left;
    logic [9:0] off_right;
    logic [9:0] off_fs;
    logic       in_click;
    logic       in_left;
    logic       in_right;
    logic       in_fs;

    assign off_click = in_keycode - r_enc_click;
    assign off_left  = in_keycode - r_enc_left;
    assign off_right = in_keycode - r_enc_right;
    assign off_fs    = in_keycode - r_footswitch;
    assign in_click  = (in_keycode >= r_enc_click)  && (off_click < 10'(NUM_ENC));
    assign in_left   = (in_keycode >= r_enc_left)   && (off_left  < 10'(NUM_ENC));
    assign in_right  = (in_keycode >= r_enc_right)  && (off_right < 10'(NUM_ENC));
    assign in_fs     = (in_keycode >= r_footswitch) && (off_fs    < 10'(NUM_FS));

    logic             dec_hit;
    t_key_kind        dec_kind;
    logic [BTN_W-1:0] dec_target;

    always_comb begin
        dec_hit    = 1'b1;
        dec_kind   = KIND_CLICK;
        dec_target = BTN_W'(off_click);
        if (in_click) begin
            dec_kind   = KIND_CLICK;
            dec_target = BTN_W'(off_click);
        end else if (in_left) begin
            dec_kind   = KIND_LEFT;
            dec_target = BTN_W'(off_left);
        end else if (in_right) begin
            dec_kind   = KIND_RIGHT;
            dec_target = BTN_W'(off_right);
        end else if (in_fs) begin
            dec_kind   = KIND_FS;
            dec_target = BTN_W'(off_fs) + BTN_W'(NUM_ENC);
        end else begin
            dec_hit = 1'b0;
        end
    end

    // The button at the head of the ring is button r_pos.
    logic [BTN_W:0] pos_ext;
    logic [BTN_W:0] unit_wide;
    logic           pos_is_fs;

    assign pos_ext   = {1'b0, r_pos};
    assign pos_is_fs = (pos_ext >= (BTN_W + 1)'(NUM_ENC));
    assign unit_wide = pos_is_fs ? (pos_ext - (BTN_W + 1)'(NUM_ENC)) : pos_ext;

    t_eval_cmd eval_cmd;
    t_entry    head_entry;
    t_entry    eval_entry;
    logic      eval_emit;
    t_result   eval_result;

    assign eval_cmd.tick  = r_tick;
    assign eval_cmd.hit   = r_key_hit && (r_pos == r_target);
    assign eval_cmd.kind  = r_kind;
    assign eval_cmd.down  = r_down;
    assign eval_cmd.is_fs = pos_is_fs;
    assign eval_cmd.unit  = 3'(unit_wide);

    efslp_eval u_eval (
        .i_cmd        (eval_cmd),
        .i_entry      (head_entry),
        .i_now        (r_now),
        .i_long_press (r_long_press),
        .o_entry      (eval_entry),
        .o_emit       (eval_emit),
        .o_result     (eval_result)
    );

    // The output register is loaded when a second result pushes the pending
    // one out during a pass, or when the pending one closes the input word.
    assign out_load = (step && eval_emit && r_pend_valid)
                   || ((r_state == ST_FLUSH) && r_pend_valid && out_free);

    // Ring of button cells: each cell takes its upper neighbour's entry, and
    // the top cell takes the updated head entry, so one full turn brings
    // every button back to its own place.
    t_entry ring [NUM_BTN];

    assign head_entry = ring[0];

    for (genvar k = 0; k < NUM_BTN; k++) begin : g_cell
        t_entry cell_in;
        if (k == NUM_BTN - 1) begin : g_top
            assign cell_in = eval_entry;
        end else begin : g_mid
            assign cell_in = ring[k + 1];
        end
        efslp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (step),
            .i_entry (cell_in),
            .o_entry (ring[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_long_press <= LONG_PRESS_RST;
            r_enc_click  <= ENC_CLICK_RST;
            r_enc_left   <= ENC_LEFT_RST;
            r_enc_right  <= ENC_RIGHT_RST;
            r_footswitch <= FOOTSWITCH_RST;
            r_now        <= 32'd0;
            r_pos        <= '0;
            r_tick       <= 1'b0;
            r_key_hit    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_LONG_PRESS: r_long_press <= pwdata[15:0];
                    REG_ENC_CLICK:  r_enc_click  <= pwdata[9:0];
                    REG_ENC_LEFT:   r_enc_left   <= pwdata[9:0];
                    REG_ENC_RIGHT:  r_enc_right  <= pwdata[9:0];
                    REG_FOOTSWITCH: r_footswitch <= pwdata[9:0];
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_pos     <= '0;
                        r_tick    <= in_mode;
                        r_key_hit <= !in_mode && dec_hit;
                        r_kind    <= dec_kind;
                        r_target  <= dec_target;
                        r_down    <= in_pressed;
                        if (in_mode) begin
                            r_now <= r_now + 32'd1;
                        end
                        r_state <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (out_free) begin
                        if (eval_emit) begin
                            if (r_pend_valid) begin
                                r_out      <= r_pend;
                                r_out_last <= 1'b0;
                            end
                            r_pend       <= eval_result;
                            r_pend_valid <= 1'b1;
                        end
                        if (r_pos == BTN_W'(NUM_BTN - 1)) begin
                            r_pos   <= '0;
                            r_state <= ST_FLUSH;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out        <= r_pend;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.turn, r_out.unit, r_out.state};
    assign m_axis_tuser  = r_out.dev;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

>>> rtl/core/efslp_cell.sv
`default_nettype none
module efslp_cell
    import efslp_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // The cell takes its neighbour's entry on every step of a pass.
    always_comb begin
        n_entry = i_shift ? i_entry : r_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '{state: BTN_RELEASED, ptime: 32'd0};
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

>>> rtl/core/efslp_eval.sv
`default_nettype none
module efslp_eval
    import efslp_pkg::*;
(
    input  t_eval_cmd   i_cmd,
    input  t_entry      i_entry,
    input  wire  [31:0] i_now,
    input  wire  [15:0] i_long_press,
    output t_entry      o_entry,
    output logic        o_emit,
    output t_result     o_result
);

    logic [31:0] held;

    assign held = i_now - i_entry.ptime;

    always_comb begin
        o_entry        = i_entry;
        o_emit         = 1'b0;
        o_result.dev   = i_cmd.is_fs;
        o_result.state = i_entry.state;
        o_result.unit  = i_cmd.unit;
        o_result.turn  = TURN_NONE;
        if (i_cmd.tick) begin
            if ((i_entry.state == BTN_PRESSED) && (held >= {16'd0, i_long_press})) begin
                o_entry.state  = BTN_LONG;
                o_entry.ptime  = 32'd0;
                o_emit         = 1'b1;
                o_result.state = BTN_LONG;
            end
        end else if (i_cmd.hit) begin
            o_emit = 1'b1;
            case (i_cmd.kind)
                KIND_CLICK, KIND_FS: begin
                    if (i_cmd.down) begin
                        o_entry.state = BTN_PRESSED;
                        o_entry.ptime = i_now;
                    end else begin
                        o_entry.state = BTN_RELEASED;
                        o_entry.ptime = 32'd0;
                    end
                    o_result.state = o_entry.state;
                end
                KIND_LEFT: begin
                    o_result.turn = TURN_LEFT;
                end
                KIND_RIGHT: begin
                    o_result.turn = TURN_RIGHT;
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/efslp_checker.sv
`default_nettype none
`include "encoder_footswitch_long_press_top_assert.svh"
module efslp_checker
    import efslp_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               s_axis_tvalid,
    input wire               s_axis_tready,
    input wire               m_axis_tvalid,
    input wire               m_axis_tready,
    input wire  [7:0]        m_axis_tdata,
    input wire               m_axis_tuser,
    input wire               m_axis_tlast
);

    // A stalled result word keeps its data and its last flag.
    `EFSLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")

    // One input word at a time: the block is busy after accepting one.
    `EFSLP_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted on consecutive cycles")

    // Button state codes never reach three and turns never read minus two.
    `EFSLP_ASSERT_NOW(a_codes, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[6:5] != 2'b10), "illegal state or turn code in result")

    // Turns are reported for encoders only.
    `EFSLP_ASSERT_NOW(a_turn_enc, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[6:5] != TURN_NONE), !m_axis_tuser, "turn reported on footswitch")

endmodule

bind encoder_footswitch_long_press_top efslp_checker u_efslp_checker (.*);
`default_nettype wire
